@@ design/rea_pkg.sv @@
// Shared types and constants of the extent allocator.
// No dependencies; the interfaces, the top level and the checker import it.
package rea_pkg;
  localparam int MAX_EXTENTS = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int LEN_W       = IDX_W + 1;
  localparam int ENTRY_W     = 2 + COUNT_BITS;

  typedef enum logic [2:0] {
    FN_RESERVE = 3'd0,
    FN_START   = 3'd1,
    FN_ALLOC   = 3'd2,
    FN_ADDREF  = 3'd3,
    FN_RELEASE = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD      = 3'd1,
    STS_RANGE    = 3'd2,
    STS_FULL     = 3'd3,
    STS_PHASE    = 3'd4,
    STS_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ES_UNRES  = 2'd0,
    ES_IN_USE = 2'd1,
    ES_FREE   = 2'd2
  } ext_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_APPEND,
    S_TRIM,
    S_TRIM_EV,
    S_FIN
  } fsm_t;
endpackage

@@ design/rea_in_if.sv @@
// Request channel of the extent allocator.
// Depends on rea_pkg.
interface rea_in_if import rea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       func;
  logic [IDX_W-1:0] extent_index;
  modport source (output valid, func, extent_index, input ready);
  modport sink   (input valid, func, extent_index, output ready);
endinterface

@@ design/rea_out_if.sv @@
// Result channel of the extent allocator.
// Depends on rea_pkg.
interface rea_out_if import rea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic [2:0]       status;
  logic [LEN_W-1:0] held_count;
  logic [LEN_W-1:0] table_length;
  modport source (output valid, result_index, status, held_count, table_length, input ready);
  modport sink   (input valid, result_index, status, held_count, table_length, output ready);
endinterface

@@ design/rea_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/refcounted_extent_allocator_core.sv @@
// Top level of the reference-counted extent allocator: sequencer and entry RAM.
// Depends on rea_pkg, rea_in_if, rea_out_if and rea_ram.
//
// One request item is taken at a time. After reset a clearing pass writes all
// 1024 entries, one a cycle, before the first item is accepted. Reserve,
// add-reference and release read their entry, evaluate it and update it, then
// put out their result; a request refused on arrival (wrong phase, out of
// range, unknown code) or a start on an empty table goes straight to its
// result. Allocate reads and evaluates each entry in turn up to the lowest free
// one, and appends a new entry when none is free; start reads and evaluates
// every table entry; a release that frees its extent then trims free entries
// off the end of the table until it meets one that is not free. A result that
// waits on the output holds off the next item. Entries are handled by a
// read-evaluate-write loop on the single entry RAM, whose read data arrives in
// the cycle after the address.
module refcounted_extent_allocator_core import rea_pkg::*; (
  input logic      clk,
  input logic      rst,
  rea_in_if.sink   in_ch,
  rea_out_if.source out_ch
);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [LEN_W-1:0]      LEN_MAX = LEN_W'(MAX_EXTENTS);

  fsm_t             state, state_next;
  logic [2:0]       func_q;
  logic [IDX_W-1:0] idx_q;
  logic [LEN_W-1:0] ptr;
  logic [IDX_W-1:0] clr_ptr;
  logic [LEN_W-1:0] used;
  logic [LEN_W-1:0] free_held;
  logic             run_phase;
  logic [IDX_W-1:0] res_q;
  status_t          status_q;
  logic             out_valid;

  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [ENTRY_W-1:0]  wdata, rdata;
  logic [1:0]          ev_st;
  logic [COUNT_BITS-1:0] ev_cnt;
  logic                accept, in_range, walk_last, out_load;
  status_t             acc_status;
  fsm_t                acc_go;

  rea_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign ev_st     = rdata[ENTRY_W-1 -: 2];
  assign ev_cnt    = rdata[COUNT_BITS-1:0];
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_range  = {1'b0, in_ch.extent_index} < used;
  assign walk_last = (ptr + LEN_W'(1)) == used;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ch.ready);

  always_comb begin
    acc_status = STS_OK;
    acc_go     = S_FIN;
    case (in_ch.func)
      FN_RESERVE: begin
        if (run_phase) acc_status = STS_PHASE;
        else acc_go = S_RD;
      end
      FN_START: begin
        if (run_phase) acc_status = STS_PHASE;
        else if (used != '0) acc_go = S_RD;
      end
      FN_ALLOC: begin
        if (!run_phase) acc_status = STS_PHASE;
        else if (used == '0) acc_go = S_APPEND;
        else acc_go = S_RD;
      end
      FN_ADDREF: begin
        if (!in_range) acc_status = STS_RANGE;
        else acc_go = S_RD;
      end
      FN_RELEASE: begin
        if (!run_phase) acc_status = STS_PHASE;
        else if (!in_range) acc_status = STS_RANGE;
        else acc_go = S_RD;
      end
      default: acc_status = STS_BAD;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr_ptr == IDX_W'(MAX_EXTENTS - 1)) state_next = S_IDLE;
      S_IDLE:    if (accept) state_next = acc_go;
      S_RD:      state_next = S_EVAL;
      S_EVAL: begin
        state_next = S_FIN;
        case (func_q)
          FN_START: if (!walk_last) state_next = S_RD;
          FN_ALLOC: begin
            if (ev_st != ES_FREE) state_next = walk_last ? S_APPEND : S_RD;
          end
          FN_RELEASE: begin
            if (ev_st == ES_IN_USE && ev_cnt == CNT_ONE) state_next = S_TRIM;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_APPEND:  state_next = S_FIN;
      S_TRIM:    state_next = (used == '0) ? S_FIN : S_TRIM_EV;
      S_TRIM_EV: state_next = (ev_st == ES_FREE) ? S_TRIM : S_FIN;
      S_FIN:     if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr[IDX_W-1:0];
    wdata = '0;
    raddr = (state == S_TRIM) ? IDX_W'(used - LEN_W'(1)) : ptr[IDX_W-1:0];
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_ptr;
      end
      S_EVAL: begin
        case (func_q)
          FN_RESERVE: if (ev_st == ES_UNRES) begin
            we = 1'b1; wdata = {ES_IN_USE, CNT_ONE};
          end
          FN_ADDREF: if (ev_st == ES_IN_USE && ev_cnt != CNT_MAX) begin
            we = 1'b1; wdata = {ES_IN_USE, ev_cnt + CNT_ONE};
          end
          FN_RELEASE: if (ev_st == ES_IN_USE && ev_cnt != '0) begin
            we    = 1'b1;
            wdata = (ev_cnt == CNT_ONE) ? {ES_FREE, {COUNT_BITS{1'b0}}}
                                        : {ES_IN_USE, ev_cnt - CNT_ONE};
          end
          FN_START: if (ev_st == ES_UNRES) begin
            we = 1'b1; wdata = {ES_FREE, ev_cnt};
          end
          FN_ALLOC: if (ev_st == ES_FREE) begin
            we = 1'b1; wdata = {ES_IN_USE, CNT_ONE};
          end
          default: we = 1'b0;
        endcase
      end
      S_APPEND: begin
        waddr = used[IDX_W-1:0];
        wdata = {ES_IN_USE, CNT_ONE};
        we    = (used != LEN_MAX);
      end
      S_TRIM_EV: begin
        waddr = IDX_W'(used - LEN_W'(1));
        we    = (ev_st == ES_FREE);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_ptr   <= '0;
      used      <= '0;
      free_held <= '0;
      run_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid           <= 1'b1;
        out_ch.result_index <= res_q;
        out_ch.status       <= status_q;
        out_ch.held_count   <= free_held;
        out_ch.table_length <= used;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: clr_ptr <= clr_ptr + IDX_W'(1);
        S_IDLE: if (accept) begin
          func_q   <= in_ch.func;
          idx_q    <= in_ch.extent_index;
          res_q    <= '0;
          status_q <= acc_status;
          ptr      <= (in_ch.func == FN_START || in_ch.func == FN_ALLOC)
                      ? '0 : {1'b0, in_ch.extent_index};
          if (in_ch.func == FN_START && !run_phase && used == '0) run_phase <= 1'b1;
        end
        S_EVAL: begin
          case (func_q)
            FN_RESERVE: begin
              if (ev_st != ES_UNRES) status_q <= STS_BAD;
              else begin
                res_q <= idx_q;
                if ({1'b0, idx_q} >= used) used <= {1'b0, idx_q} + LEN_W'(1);
              end
            end
            FN_ADDREF: begin
              if (ev_st != ES_IN_USE) status_q <= STS_BAD;
              else if (ev_cnt == CNT_MAX) status_q <= STS_OVERFLOW;
              else res_q <= idx_q;
            end
            FN_RELEASE: begin
              if (ev_st != ES_IN_USE || ev_cnt == '0) status_q <= STS_BAD;
              else begin
                res_q <= idx_q;
                if (ev_cnt == CNT_ONE) free_held <= free_held + LEN_W'(1);
              end
            end
            FN_START: begin
              if (ev_st == ES_UNRES) free_held <= free_held + LEN_W'(1);
              ptr <= ptr + LEN_W'(1);
              if (walk_last) run_phase <= 1'b1;
            end
            FN_ALLOC: begin
              if (ev_st == ES_FREE) begin
                res_q <= ptr[IDX_W-1:0];
                if (free_held != '0) free_held <= free_held - LEN_W'(1);
              end else begin
                ptr <= ptr + LEN_W'(1);
              end
            end
            default: status_q <= STS_BAD;
          endcase
        end
        S_APPEND: begin
          if (used == LEN_MAX) status_q <= STS_FULL;
          else begin
            res_q <= used[IDX_W-1:0];
            used  <= used + LEN_W'(1);
          end
        end
        S_TRIM_EV: if (ev_st == ES_FREE) begin
          used <= used - LEN_W'(1);
          if (free_held != '0) free_held <= free_held - LEN_W'(1);
        end
        default: clr_ptr <= clr_ptr;
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
endmodule

@@ design/rea_checker.sv @@
// Port-level checks of the extent allocator, bound to the top level.
// Depends on rea_pkg and refcounted_extent_allocator_core.
module rea_checker import rea_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       status,
  input logic [LEN_W-1:0] held_count,
  input logic [LEN_W-1:0] table_length
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result item dropped");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'(STS_OVERFLOW)) else $error("unknown status");
  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_count <= table_length) else $error("held count exceeds table");
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> table_length <= LEN_W'(MAX_EXTENTS)) else $error("table too long");
endmodule

bind refcounted_extent_allocator_core rea_checker u_rea_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .held_count(out_ch.held_count),
  .table_length(out_ch.table_length)
);
